[design/ipe_pkg.sv]
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared types and constants of the invariant permutation enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipe_pkg;

  // field widths fixed by the interface
  localparam int unsigned POS_W      = 3;
  localparam int unsigned ORDER_W    = 24;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned NUM_LABELS = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned IN_DATA_W  = 8;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_SET  = 2'd1;

  // reset value of the item count register
  localparam logic [CNT_W-1:0] ITEM_COUNT_RST = 4'd8;

  // kind of request after classification
  typedef enum logic {
    CMD_CONTINUE = 1'b0,
    CMD_RESTART  = 1'b1
  } cmd_kind_e;

  // one queued request with its valid flag
  typedef struct packed {
    logic      valid;
    cmd_kind_e kind;
  } cmd_beat_t;

  typedef logic [LABEL_W-1:0] label_t;

endpackage

`default_nettype wire

[design/ipe_front.sv]
// ----------------------------------------------------------------------------
// ipe_front
// Accepts request beats and classifies them as restart or continue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_front
  import ipe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire logic      req_restart_i,
  input  wire logic      queue_full_i,
  output cmd_beat_t      push_o
);

  logic started_q, started_d;

  // accept whenever the queue has room
  assign req_ready_o = !queue_full_i;

  // a continue before any restart is taken as a restart
  always_comb begin
    push_o.valid = req_valid_i && !queue_full_i;
    push_o.kind  = (req_restart_i || !started_q) ? CMD_RESTART : CMD_CONTINUE;
    started_d    = started_q || push_o.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

[design/ipe_queue.sv]
// ----------------------------------------------------------------------------
// ipe_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_queue
  import ipe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_beat_t push_i,
  output logic           full_o,
  output cmd_beat_t      head_o,
  input  wire logic      pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_kind_e            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]    count_q, count_d;
  logic                 do_pop;

  assign full_o       = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.kind  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + CNT_QW'(1);
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.kind;
    end
  end

endmodule

`default_nettype wire

[design/ipe_back.sv]
// ----------------------------------------------------------------------------
// ipe_back
// Executes requests: one lexicographic successor step and label check per
// cycle, with a result register toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_back
  import ipe_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 8,
  parameter int unsigned LABEL_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_beat_t          head_i,
  output logic                    pop_o,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [CFG_W-1:0]   label_set_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [ORDER_W-1:0]      res_order_o,
  output logic                    res_found_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;

  logic                 state_q, state_d;
  logic [POS_W-1:0]     ord_q [MAX_ITEMS];
  logic [POS_W-1:0]     ord_d [MAX_ITEMS];
  logic                 exhausted_q, exhausted_d;
  logic                 valid_q, valid_d;
  logic [ORDER_W-1:0]   order_q, order_d;
  logic                 found_q, found_d;

  label_t               labels [NUM_LABELS];
  logic                 k_found;
  logic [IDX_W-1:0]     k_idx;
  logic [IDX_W-1:0]     l_idx;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     src;
  logic [POS_W-1:0]     sw   [MAX_ITEMS];
  logic [POS_W-1:0]     adv  [MAX_ITEMS];
  logic                 pass;
  logic [ORDER_W-1:0]   pack_adv;
  logic [ORDER_W-1:0]   pack_id;
  logic                 slot_free;

  // unpack the label tuple
  always_comb begin
    for (int i = 0; i < NUM_LABELS; i++) begin
      labels[i] = label_set_i[i*LABEL_W +: LABEL_W];
    end
  end

  // successor step: pivot, swap partner, tail reversal, then label check
  always_comb begin
    k_found = 1'b0;
    k_idx   = '0;
    l_idx   = '0;
    src     = '0;
    for (int j = 1; j < MAX_ITEMS; j++) begin
      if (CNT_W'(j) < count_i && ord_q[j-1] < ord_q[j]) begin
        k_found = 1'b1;
        k_idx   = IDX_W'(j - 1);
      end
    end
    for (int j = 0; j < MAX_ITEMS; j++) begin
      if (IDX_W'(j) > k_idx && CNT_W'(j) < count_i && ord_q[j] > ord_q[k_idx]) begin
        l_idx = IDX_W'(j);
      end
    end
    sw = ord_q;
    if (k_found) begin
      sw[k_idx] = ord_q[l_idx];
      sw[l_idx] = ord_q[k_idx];
    end
    // without a pivot the whole live range turns back to ascending order
    lo  = k_found ? (CNT_W'(k_idx) + CNT_W'(1)) : '0;
    adv = sw;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (CNT_W'(i) >= lo && CNT_W'(i) < count_i) begin
        src    = lo + count_i - CNT_W'(1) - CNT_W'(i);
        adv[i] = sw[src[IDX_W-1:0]];
      end
    end
    pass = 1'b1;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (CNT_W'(i) < count_i &&
          labels[i][LABEL_BITS-1:0] != labels[adv[i]][LABEL_BITS-1:0]) begin
        pass = 1'b0;
      end
    end
  end

  // packed views of the stepped order and of the identity
  always_comb begin
    pack_adv = '0;
    pack_id  = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (CNT_W'(i) < count_i) begin
        pack_adv[i*POS_W +: POS_W] = adv[i];
        pack_id[i*POS_W +: POS_W]  = POS_W'(i);
      end
    end
  end

  assign slot_free = !valid_q || res_ready_i;

  // request sequencing
  always_comb begin
    state_d     = state_q;
    ord_d       = ord_q;
    exhausted_d = exhausted_q;
    valid_d     = valid_q && !res_ready_i;
    order_d     = order_q;
    found_d     = found_q;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && slot_free) begin
          pop_o = 1'b1;
          if (head_i.kind == CMD_RESTART) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
              ord_d[i] = POS_W'(i);
            end
            exhausted_d = 1'b0;
            valid_d     = 1'b1;
            order_d     = pack_id;
            found_d     = 1'b1;
          end else if (exhausted_q) begin
            valid_d = 1'b1;
            order_d = '0;
            found_d = 1'b0;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        ord_d = adv;
        if (!k_found) begin
          exhausted_d = 1'b1;
          valid_d     = 1'b1;
          order_d     = '0;
          found_d     = 1'b0;
          state_d     = ST_IDLE;
        end else if (pass) begin
          valid_d = 1'b1;
          order_d = pack_adv;
          found_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exhausted_q <= 1'b0;
      valid_q     <= 1'b0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
        ord_q[i] <= POS_W'(i);
      end
    end else begin
      state_q     <= state_d;
      exhausted_q <= exhausted_d;
      valid_q     <= valid_d;
      ord_q       <= ord_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    order_q <= order_d;
    found_q <= found_d;
  end

  assign res_valid_o = valid_q;
  assign res_order_o = order_q;
  assign res_found_o = found_q;

endmodule

`default_nettype wire

[design/invariant_permutation_enumerator.sv]
// Timing: a restart, or a continue once the list is exhausted, passes through the queue entry
//   and then the result register, waiting while that register holds an untaken result; a
//   continue first runs next-permutation steps (one per cycle) up to the next passing order.
// Flow: one request at a time in the stepping unit; the two-entry queue keeps
//   accepting until full while a result waits in the output register.
// Reset: asynchronous, active low; item_count 8, labels 0, identity order, not started.
// ----------------------------------------------------------------------------
// invariant_permutation_enumerator
// Streams the label-preserving permutations of the live positions in
// lexicographic order, one per request beat.
// ----------------------------------------------------------------------------
`default_nettype none

module invariant_permutation_enumerator
  import ipe_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 8,
  parameter int unsigned LABEL_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [ORDER_W-1:0]         m_axis_tdata,   // [23:0] order
  output logic                       m_axis_tuser,   // [0] found
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  logic [CNT_W-1:0]  item_count_q;
  logic [CFG_W-1:0]  label_set_q;
  logic [CNT_W-1:0]  live_count;
  logic              queue_full;
  cmd_beat_t         push;
  cmd_beat_t         head;
  logic              pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= ITEM_COUNT_RST;
      label_set_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ITEM_COUNT: item_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_LABEL_SET:  label_set_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // live position count clamped to one up to MAX_ITEMS
  always_comb begin
    if (item_count_q == '0) begin
      live_count = CNT_W'(1);
    end else if (item_count_q > CNT_W'(MAX_ITEMS)) begin
      live_count = CNT_W'(MAX_ITEMS);
    end else begin
      live_count = item_count_q;
    end
  end

  ipe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_restart_i (s_axis_tdata[0]),
    .queue_full_i  (queue_full),
    .push_o        (push)
  );

  ipe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ipe_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .LABEL_BITS (LABEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .count_i     (live_count),
    .label_set_i (label_set_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_order_o (m_axis_tdata),
    .res_found_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
